@@ design/gwwp_pkg.sv @@
// Shared constants and helpers for the greedy word-wrap paginator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gwwp_pkg;

   // Longest line and word buffer depth
   localparam int MAX_LINE   = 63;
   localparam int WORD_DEPTH = 63;
   localparam int ADDR_W     = 6;
   localparam int CHAR_W     = 8;
   localparam int CPL_W      = 6;
   localparam int LPP_W      = 8;
   localparam int CSR_DATA_W = 8;

   // Character codes
   localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_NL  = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_VT  = 8'd11;
   localparam logic [CHAR_W-1:0] CHAR_FF  = 8'd12;
   localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_SP  = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_NUL = 8'd0;

   // Register indexes
   localparam logic CSR_CHARS_PER_LINE = 1'b0;
   localparam logic CSR_LINES_PER_PAGE = 1'b1;

   // Word buffer write and read requests
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [CHAR_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   // True for bytes that separate words (newline excluded)
   function automatic logic is_blank(input logic [CHAR_W-1:0] ch);
      is_blank = (ch == CHAR_TAB) || (ch == CHAR_VT) || (ch == CHAR_FF) ||
                 (ch == CHAR_CR) || (ch == CHAR_SP);
   endfunction

endpackage

@@ design/gwwp_word_ram.sv @@
// Word buffer: one write port, one read port, registered read data.
// Depends on gwwp_pkg.
`timescale 1ns / 1ps

module gwwp_word_ram import gwwp_pkg::*; (
   input  logic              clock,
   input  ram_wr_type        wr,
   input  ram_rd_type        rd,
   output logic [CHAR_W-1:0] rd_data
);

   logic [CHAR_W-1:0] mem [WORD_DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/greedy_word_wrap_paginator_top.sv @@
// Top level of the greedy word-wrap paginator: layout control and result register.
// Depends on gwwp_pkg and gwwp_word_ram.
//
//   channel  ports                              direction  transfer when
//   req      req_valid/req_stall + 2 fields     in         req_valid && !req_stall
//   rsp      rsp_valid/rsp_stall + 5 fields     out        rsp_valid && !rsp_stall
//   csr      csr_write_en/index/write_data      in         csr_write_en
//
// A word byte that does not end a word is taken without a stall and the next byte
// can follow at once. A byte that places a word holds the input while the
// word is read back from the buffer RAM at one character per cycle when the result
// is not stalled, set by its single read port. Reset is synchronous and
// needs no clearing pass. A stalled result holds the read-out in place.
`timescale 1ns / 1ps

module greedy_word_wrap_paginator_top import gwwp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic                  req_end_of_text,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAR_W-1:0]     rsp_out_char,
   output logic                  rsp_has_char,
   output logic                  rsp_page_start,
   output logic                  rsp_run_end,
   output logic                  rsp_text_end,
   // configuration
   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_PLACE, ST_FINISH} state_type;
   typedef enum logic [1:0] {SEP_NONE, SEP_SPACE, SEP_NEWLINE} sep_type;

   state_type         state_ff, state_in;
   sep_type           sep_ff, sep_in;

   // configuration
   logic [CPL_W-1:0]  cpl_ff, cpl_in;
   logic [LPP_W-1:0]  lpp_ff, lpp_in;

   // layout state
   logic [ADDR_W-1:0] wl_ff, wl_in;
   logic [ADDR_W-1:0] ll_ff, ll_in;
   logic              any_ff, any_in;
   logic [LPP_W-1:0]  ldop_ff, ldop_in;

   // item being placed
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic              eot_ff, eot_in;
   logic              keep_ff, keep_in;
   logic              marker_ff, marker_in;
   logic              mark_ff, mark_in;
   logic [ADDR_W-1:0] len_ff, len_in;
   logic [ADDR_W-1:0] rd_idx_ff, rd_idx_in;

   // read data tag
   logic              p_ff, p_in;
   logic              p_mark_ff, p_mark_in;
   logic              p_last_ff, p_last_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] out_char_ff, out_char_in;
   logic              has_char_ff, has_char_in;
   logic              page_start_ff, page_start_in;
   logic              run_end_ff, run_end_in;
   logic              text_end_ff, text_end_in;

   ram_wr_type        ram_wr;
   ram_rd_type        ram_rd;
   logic [CHAR_W-1:0] ram_rd_data;

   logic              out_free;
   logic              active;
   logic              is_nl;
   logic              is_sep;
   logic              place_now;
   logic              fits;
   logic [LPP_W:0]    done_cnt;
   logic [ADDR_W:0]   joined_len;

   gwwp_word_ram u_word_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rd_data)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign active     = (cpl_ff != '0) && (lpp_ff != '0);
   assign is_nl      = (req_char_code == CHAR_NL);
   assign is_sep     = is_blank(req_char_code);
   assign joined_len = {1'b0, ll_ff} + {{ADDR_W{1'b0}}, 1'b1} + {1'b0, wl_ff};
   assign fits       = (ll_ff != '0) && (joined_len <= {1'b0, cpl_ff});
   assign done_cnt   = {1'b0, ldop_ff} + {{LPP_W{1'b0}}, 1'b1};

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      sep_in        = sep_ff;
      cpl_in        = cpl_ff;
      lpp_in        = lpp_ff;
      wl_in         = wl_ff;
      ll_in         = ll_ff;
      any_in        = any_ff;
      ldop_in       = ldop_ff;
      ch_in         = ch_ff;
      eot_in        = eot_ff;
      keep_in       = keep_ff;
      marker_in     = marker_ff;
      mark_in       = mark_ff;
      len_in        = len_ff;
      rd_idx_in     = rd_idx_ff;
      p_in          = p_ff;
      p_mark_in     = p_mark_ff;
      p_last_in     = p_last_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_char_in   = out_char_ff;
      has_char_in   = has_char_ff;
      page_start_in = page_start_ff;
      run_end_in    = run_end_ff;
      text_end_in   = text_end_ff;
      ram_wr        = '0;
      ram_rd        = '0;
      place_now     = 1'b0;

      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      // configuration writes
      if (csr_write_en) begin
         case (csr_index)
            CSR_CHARS_PER_LINE: cpl_in = csr_write_data[CPL_W-1:0];
            CSR_LINES_PER_PAGE: lpp_in = csr_write_data[LPP_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ch_in     = req_char_code;
               eot_in    = req_end_of_text;
               len_in    = wl_ff;
               rd_idx_in = '0;
               sep_in    = SEP_NONE;
               mark_in   = 1'b0;
               keep_in   = 1'b0;
               marker_in = 1'b0;
               if (req_end_of_text) begin
                  place_now = active && (wl_ff != '0);
               end else if (active) begin
                  if (is_nl || is_sep) begin
                     place_now = (wl_ff != '0);
                  end else begin
                     place_now = ({1'b0, wl_ff} >= {1'b0, cpl_ff});
                  end
               end

               // place the pending word: separator, page mark, line length
               if (place_now) begin
                  if (fits) begin
                     sep_in = SEP_SPACE;
                     ll_in  = joined_len[ADDR_W-1:0];
                  end else begin
                     if (any_ff) begin
                        if (done_cnt >= {1'b0, lpp_ff}) begin
                           ldop_in = '0;
                           mark_in = 1'b1;
                        end else begin
                           ldop_in = done_cnt[LPP_W-1:0];
                           sep_in  = SEP_NEWLINE;
                        end
                     end
                     any_in = 1'b1;
                     ll_in  = wl_ff;
                  end
                  wl_in = '0;
               end

               if (req_end_of_text) begin
                  // layout state back to reset values; bare marker if nothing is flushed
                  wl_in     = '0;
                  ll_in     = '0;
                  any_in    = 1'b0;
                  ldop_in   = '0;
                  marker_in = !place_now;
                  state_in  = place_now ? ST_PLACE : ST_FINISH;
               end else if (active) begin
                  if (is_nl) begin
                     ll_in = '0;
                  end
                  if (place_now) begin
                     keep_in  = !(is_nl || is_sep);
                     state_in = ST_PLACE;
                  end else if (!(is_nl || is_sep) && ({1'b0, wl_ff} < 7'(WORD_DEPTH))) begin
                     ram_wr.en   = 1'b1;
                     ram_wr.addr = wl_ff;
                     ram_wr.data = req_char_code;
                     wl_in       = wl_ff + 6'd1;
                  end
               end
            end
         end

         ST_PLACE: begin
            // result register: separator first, then word characters
            if (out_free) begin
               if (sep_ff != SEP_NONE) begin
                  rsp_valid_in  = 1'b1;
                  out_char_in   = (sep_ff == SEP_SPACE) ? CHAR_SP : CHAR_NL;
                  has_char_in   = 1'b1;
                  page_start_in = 1'b0;
                  run_end_in    = 1'b0;
                  text_end_in   = 1'b0;
                  sep_in        = SEP_NONE;
               end else if (p_ff) begin
                  rsp_valid_in  = 1'b1;
                  out_char_in   = ram_rd_data;
                  has_char_in   = 1'b1;
                  page_start_in = p_mark_ff;
                  run_end_in    = p_last_ff;
                  text_end_in   = p_last_ff && eot_ff;
                  p_in          = 1'b0;
               end
            end

            // issue the next buffer read once the read data slot frees up
            if ((rd_idx_ff != len_ff) && (!p_ff || (out_free && sep_ff == SEP_NONE))) begin
               ram_rd.en   = 1'b1;
               ram_rd.addr = rd_idx_ff;
               p_in        = 1'b1;
               p_mark_in   = mark_ff && (rd_idx_ff == '0);
               p_last_in   = (rd_idx_ff == len_ff - 6'd1);
               rd_idx_in   = rd_idx_ff + 6'd1;
            end

            if ((rd_idx_ff == len_ff) && !p_ff && (sep_ff == SEP_NONE)) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // the byte that ended the word starts the next one
            if (keep_ff) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = '0;
               ram_wr.data = ch_ff;
               wl_in       = 6'd1;
               keep_in     = 1'b0;
            end
            if (marker_ff) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  out_char_in   = CHAR_NUL;
                  has_char_in   = 1'b0;
                  page_start_in = 1'b0;
                  run_end_in    = 1'b1;
                  text_end_in   = 1'b1;
                  marker_in     = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sep_ff       <= SEP_NONE;
         cpl_ff       <= '0;
         lpp_ff       <= '0;
         wl_ff        <= '0;
         ll_ff        <= '0;
         any_ff       <= 1'b0;
         ldop_ff      <= '0;
         keep_ff      <= 1'b0;
         marker_ff    <= 1'b0;
         p_ff         <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sep_ff       <= sep_in;
         cpl_ff       <= cpl_in;
         lpp_ff       <= lpp_in;
         wl_ff        <= wl_in;
         ll_ff        <= ll_in;
         any_ff       <= any_in;
         ldop_ff      <= ldop_in;
         keep_ff      <= keep_in;
         marker_ff    <= marker_in;
         p_ff         <= p_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff         <= ch_in;
      eot_ff        <= eot_in;
      mark_ff       <= mark_in;
      len_ff        <= len_in;
      rd_idx_ff     <= rd_idx_in;
      p_mark_ff     <= p_mark_in;
      p_last_ff     <= p_last_in;
      out_char_ff   <= out_char_in;
      has_char_ff   <= has_char_in;
      page_start_ff <= page_start_in;
      run_end_ff    <= run_end_in;
      text_end_ff   <= text_end_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_char   = out_char_ff;
   assign rsp_has_char   = has_char_ff;
   assign rsp_page_start = page_start_ff;
   assign rsp_run_end    = run_end_ff;
   assign rsp_text_end   = text_end_ff;

endmodule

@@ tb/sv/tb_greedy_word_wrap_paginator_top.sv @@
// Self-checking bench for greedy_word_wrap_paginator_top: directed and random text,
// random idle bursts on both channels, layout predicted in the bench itself.
// Depends on gwwp_pkg and the paginator RTL.
`timescale 1ns / 1ps

module tb_greedy_word_wrap_paginator_top import gwwp_pkg::*; ();

   localparam int SETTLE_CYCLES = 80;   // longest word read-out plus margin
   localparam int TEXT_TARGET   = 230;  // counted bytes before the final quiet phase

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              eot;
   } text_byte_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              has;
      logic              mark;
      logic              run_last;
      logic              text_last;
   } glyph_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CHAR_W-1:0]     req_char_code = '0;
   logic                  req_end_of_text = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CHAR_W-1:0]     rsp_out_char;
   logic                  rsp_has_char;
   logic                  rsp_page_start;
   logic                  rsp_run_end;
   logic                  rsp_text_end;
   logic                  csr_write_en = 1'b0;
   logic                  csr_index = CSR_CHARS_PER_LINE;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   greedy_word_wrap_paginator_top dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Text waiting to be sent and laid-out glyphs still owed by the block
   text_byte_type text_q[$];
   glyph_type     layout_q[$];
   glyph_type     burst_q[$];      // glyphs caused by the byte being predicted
   int         bytes_owed = 0;  // bytes queued but not yet transferred
   int         counted = 0;     // random bytes queued while layout was enabled
   int         fail_count = 0;
   bit         calm = 1'b0;     // no idle bursts on either side
   int         gap_left = 0;
   int         hold_left = 0;

   // Layout model state
   int          wrap_width = 0;
   int          page_height = 0;
   logic [7:0]  word_buf [WORD_DEPTH];
   int          word_len = 0;
   int          line_len = 0;
   logic        line_open = 1'b0;
   int          page_lines = 0;

   function automatic logic is_gap(input logic [CHAR_W-1:0] c);
      case (c)
         CHAR_TAB, CHAR_VT, CHAR_FF, CHAR_CR, CHAR_SP: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic void put_glyph(input logic [CHAR_W-1:0] c, input logic h,
                                     input logic m);
      glyph_type g;
      g = '0;
      g.ch = c;
      g.has = h;
      g.mark = m;
      if (burst_q.size() < MAX_LINE + 1) burst_q.insert(burst_q.size(), g);
   endfunction

   // New line: a newline inside the page, or a page mark once the page is full
   function automatic logic start_line();
      logic m;
      m = 1'b0;
      if (line_open) begin
         if (page_lines + 1 >= page_height) begin
            page_lines = 0;
            m = 1'b1;
         end else begin
            page_lines = page_lines + 1;
            put_glyph(CHAR_NL, 1'b1, 1'b0);
         end
      end
      line_open = 1'b1;
      line_len = 0;
      return m;
   endfunction

   // Put the pending word on the current line if it fits, else on a new one
   function automatic void set_word();
      int   span;
      int   i;
      logic m;
      span = word_len;
      m = 1'b0;
      if (word_len == 0) return;
      if (line_len != 0 && line_len + 1 + word_len <= wrap_width) begin
         put_glyph(CHAR_SP, 1'b1, 1'b0);
         span = word_len + line_len + 1;
      end else begin
         m = start_line();
      end
      for (i = 0; i < word_len; i++)
         put_glyph(word_buf[ADDR_W'(i)], 1'b1, (i == 0) ? m : 1'b0);
      line_len = (span > MAX_LINE) ? MAX_LINE : span;
      word_len = 0;
   endfunction

   function automatic void predict_layout(input logic [CHAR_W-1:0] code, input logic eot);
      glyph_type g;
      logic   live;
      burst_q.delete();
      live = (wrap_width != 0) && (page_height != 0);
      if (eot) begin
         if (live) set_word();
         if (burst_q.size() == 0) put_glyph(CHAR_NUL, 1'b0, 1'b0);
         word_len = 0;
         line_len = 0;
         line_open = 1'b0;
         page_lines = 0;
      end else if (live) begin
         if (code == CHAR_NL) begin
            set_word();
            line_len = 0;
         end else if (is_gap(code)) begin
            set_word();
         end else begin
            // a full word is cut before the next byte joins it
            if (word_len >= wrap_width) set_word();
            if (word_len < WORD_DEPTH) begin
               word_buf[ADDR_W'(word_len)] = code;
               word_len++;
            end
         end
      end
      if (burst_q.size() != 0) begin
         g = burst_q.pop_back();
         g.run_last = 1'b1;
         g.text_last = eot;
         burst_q.insert(burst_q.size(), g);
      end
      foreach (burst_q[i]) layout_q.insert(layout_q.size(), burst_q[i]);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%02h expected 0x%02h", name, got, want));
   endtask

   // Sender: one byte per transfer, random idle bursts between bytes
   always @(posedge clock) begin
      text_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_layout(req_char_code, req_end_of_text);
            bytes_owed--;
         end
         if (req_valid && req_stall) begin
            // hold the stalled byte
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (!calm && text_q.size() != 0 && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 18);
            req_valid <= 1'b0;
         end else if (text_q.size() != 0) begin
            nxt = text_q.pop_front();
            req_valid <= 1'b1;
            req_char_code <= nxt.code;
            req_end_of_text <= nxt.eot;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: compare each transfer with the oldest owed glyph, stall in bursts
   always @(posedge clock) begin
      glyph_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (layout_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result, out_char 0x%02h", rsp_out_char));
            end else begin
               want = layout_q.pop_front();
               check_field("out_char", rsp_out_char, want.ch);
               check_field("has_char", 8'(rsp_has_char), 8'(want.has));
               check_field("page_start", 8'(rsp_page_start), 8'(want.mark));
               check_field("run_end", 8'(rsp_run_end), 8'(want.run_last));
               check_field("text_end", 8'(rsp_text_end), 8'(want.text_last));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(0, 18);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic add_item(input logic [CHAR_W-1:0] code, input logic eot);
      text_byte_type t;
      t.code = code;
      t.eot = eot;
      bytes_owed++;
      text_q.insert(text_q.size(), t);
   endtask

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) add_item(s[i], 1'b0);
   endtask

   // char_code is ignored with end_of_text, so it carries noise
   task automatic add_end();
      add_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic logic [CHAR_W-1:0] word_byte();
      logic [CHAR_W-1:0] c;
      if ($urandom_range(0, 3) != 0) return 8'($urandom_range(33, 126));
      do c = 8'($urandom_range(0, 255)); while (is_gap(c) || c == CHAR_NL);
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] gap_byte();
      case ($urandom_range(0, 9))
         0, 1:    return CHAR_NL;
         2:       return CHAR_TAB;
         3:       return CHAR_VT;
         4:       return CHAR_FF;
         5:       return CHAR_CR;
         default: return CHAR_SP;
      endcase
   endfunction

   // Mostly words with separators; some stray bytes and early text ends
   task automatic add_random_text(input int budget);
      int   made;
      int   wlen;
      int   roll;
      int   k;
      logic live;
      made = 0;
      live = (wrap_width != 0) && (page_height != 0);
      while (made < budget) begin
         roll = $urandom_range(0, 99);
         if (roll < 80) begin
            wlen = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 8);
            for (k = 0; k < wlen; k++) add_item(word_byte(), 1'b0);
            add_item(gap_byte(), 1'b0);
            made += wlen + 1;
         end else if (roll < 95) begin
            add_item(8'($urandom_range(0, 255)), 1'b0);
            made++;
         end else begin
            add_end();
            made++;
         end
      end
      if (live) counted += made;
   endtask

   // Wait for every byte to be taken and every glyph to arrive, then let the block settle
   task automatic wait_idle();
      while (bytes_owed != 0 || layout_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      if (idx == CSR_CHARS_PER_LINE) wrap_width = int'(data[CPL_W-1:0]);
      else page_height = int'(data);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Upper bits of the line width write are don't-care and get noise
   task automatic set_layout(input int cpl, input int lpp);
      write_csr(CSR_CHARS_PER_LINE, {2'($urandom_range(0, 3)), 6'(cpl)});
      write_csr(CSR_LINES_PER_PAGE, 8'(lpp));
   endtask

   initial begin
      int phase;
      int cpl;
      int lpp;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Registers still zero: bytes ignored, end gives a bare marker
      add_item("q", 1'b0);
      add_end();
      wait_idle();

      // Every separator, newline on full and empty line, a cut word, extreme bytes
      set_layout(4, 2);
      add_text("ab");
      add_item(CHAR_TAB, 1'b0);
      add_text("cd");
      add_item(CHAR_VT, 1'b0);
      add_text("e");
      add_item(CHAR_FF, 1'b0);
      add_text("f");
      add_item(CHAR_CR, 1'b0);
      add_item(CHAR_NL, 1'b0);
      add_item(CHAR_NL, 1'b0);
      add_text("012345");
      add_item(CHAR_SP, 1'b0);
      add_item(8'h00, 1'b0);
      add_item(8'hFF, 1'b0);
      wait_idle();

      // Width shrunk under a pending word: the word goes out whole on one line
      set_layout(1, 2);
      add_text("z");
      wait_idle();

      // Page height cleared under a pending word: the end discards it
      write_csr(CSR_LINES_PER_PAGE, 8'd0);
      add_end();
      wait_idle();

      // Random phases, extremes first; text often left open across a change
      phase = 0;
      while (counted < TEXT_TARGET) begin
         case (phase)
            0: begin cpl = 1;  lpp = 1;   end
            1: begin cpl = 63; lpp = 255; end
            2: begin cpl = 63; lpp = 1;   end
            3: begin cpl = 1;  lpp = 255; end
            default: begin
               cpl = ($urandom_range(0, 1) != 0) ? $urandom_range(2, 12) : $urandom_range(1, 63);
               lpp = ($urandom_range(0, 1) != 0) ? $urandom_range(2, 5) : $urandom_range(1, 255);
               if ($urandom_range(0, 11) == 0) cpl = 0;
               else if ($urandom_range(0, 11) == 0) lpp = 0;
            end
         endcase
         calm = ($urandom_range(0, 3) == 0);
         set_layout(cpl, lpp);
         add_random_text((cpl == 0 || lpp == 0) ? 6 : $urandom_range(25, 45));
         if ($urandom_range(0, 1) != 0) add_end();
         wait_idle();
         phase++;
      end

      // Final stretch at full rate on both sides
      calm = 1'b1;
      set_layout($urandom_range(3, 20), $urandom_range(2, 4));
      add_random_text(40);
      add_end();
      wait_idle();

      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
